// ===== hdl/dn2cd_pkg.sv =====
package dn2cd_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_NORMAL  = 2'd0;
  localparam status_t ST_NEG_INF = 2'd1;
  localparam status_t ST_POS_INF = 2'd2;
  localparam status_t ST_RANGE   = 2'd3;

  localparam int unsigned InWidth    = 32;
  localparam int unsigned YearWidth  = 24;
  localparam int unsigned MonthWidth = 4;
  localparam int unsigned DayWidth   = 5;
  localparam int unsigned DataWidth  = 40;

  localparam logic [31:0] EPOCH_JDAY   = 32'd2451545;
  localparam logic [31:0] JD_BIAS      = 32'd32044;
  localparam logic [31:0] DAYS_400Y    = 32'd146097;
  localparam logic [31:0] DAYS_4Y      = 32'd1461;
  localparam logic [14:0] RECIP_400Y   = 15'd29398;
  localparam logic [21:0] RECIP_4Y     = 22'd2939744;
  localparam logic [23:0] YEAR_BIAS    = 24'd4800;
  localparam logic [11:0] MONTH_MUL    = 12'd2141;
  localparam logic [12:0] DAY_MUL      = 13'd7834;

endpackage

// ===== hdl/day_number_to_calendar_date.sv =====
// Converts a signed count of days since 2000-01-01 into a proleptic Gregorian
// calendar date. Each input word on the s_axis channel carries one day count.
// Each output word on the m_axis channel carries the year, month, day of
// month and a flag for years at or before 1 BC, and tuser gives the status:
// normal, minus infinity, plus infinity or out of range. For a status other
// than normal all date fields are zero.
// The pipeline has eleven register stages, 0 to 10, and a word accepted on
// s_axis passes through them in order and is presented on m_axis from stage
// 10. One word can be accepted every cycle while the output does not stall.
// The two constant divisions are done as reciprocal multiplications, each
// followed by a stage for the remainder and a stage for the single
// correction step, which sets the stage count.
// Reset clears all valid bits; the pipeline then stands empty and ready.
// When the receiver holds m_axis_tready low, each stage keeps its word until
// the stage after it frees up, so empty stages still fill and s_axis_tready
// drops only once every stage holds a word. Nothing is lost or repeated.
module day_number_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] day_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [23:0] year, [27:24] month,
                                      // [32:28] day_of_month, [33] before_christ
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned NumStages = 11;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;
  dn2cd_pkg::status_t   stat_q [NumStages];

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // Stage 0: epoch offset and classification.
  logic [32:0]        jday;
  dn2cd_pkg::status_t stat0_d;
  logic [31:0]        s0_acc_d, s0_acc_q;

  assign jday = {s_axis_tdata[31], s_axis_tdata} + {1'b0, dn2cd_pkg::EPOCH_JDAY};

  always_comb begin
    if (s_axis_tdata == 32'h8000_0000) begin
      stat0_d = dn2cd_pkg::ST_NEG_INF;
    end else if (s_axis_tdata == 32'h7FFF_FFFF) begin
      stat0_d = dn2cd_pkg::ST_POS_INF;
    end else if (jday[32] || jday[31]) begin
      stat0_d = dn2cd_pkg::ST_RANGE;
    end else begin
      stat0_d = dn2cd_pkg::ST_NORMAL;
    end
  end

  assign s0_acc_d = jday[31:0] + dn2cd_pkg::JD_BIAS;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_acc_q <= s0_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      stat_q[0] <= stat0_d;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) begin
        stat_q[i] <= stat_q[i-1];
      end
    end
  end

  // Stage 1: estimate of the 400-year group.
  logic [46:0] prod1;
  logic [31:0] s1_acc_q;
  logic [13:0] s1_qe_d, s1_qe_q;

  assign prod1   = 47'(s0_acc_q) * 47'(dn2cd_pkg::RECIP_400Y);
  assign s1_qe_d = prod1[45:32];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_acc_q <= s0_acc_q;
      s1_qe_q  <= s1_qe_d;
    end
  end

  // Stage 2: remainder of the estimate.
  logic [31:0] sub1;
  logic [31:0] s2_acc_q;
  logic [13:0] s2_qe_q;
  logic [18:0] s2_rem_d, s2_rem_q;

  assign sub1     = s1_acc_q - 32'(s1_qe_q) * dn2cd_pkg::DAYS_400Y;
  assign s2_rem_d = sub1[18:0];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_acc_q <= s1_acc_q;
      s2_qe_q  <= s1_qe_q;
      s2_rem_q <= s2_rem_d;
    end
  end

  // Stage 3: correction of the 400-year quotient.
  logic        fix1;
  logic [31:0] s3_acc_q;
  logic [13:0] s3_grp_d, s3_grp_q;
  logic [17:0] s3_rem_d, s3_rem_q;
  logic [18:0] rem1_adj;

  assign fix1     = s2_rem_q >= dn2cd_pkg::DAYS_400Y[18:0];
  assign rem1_adj = s2_rem_q - dn2cd_pkg::DAYS_400Y[18:0];
  assign s3_grp_d = fix1 ? s2_qe_q + 14'd1 : s2_qe_q;
  assign s3_rem_d = fix1 ? rem1_adj[17:0] : s2_rem_q[17:0];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_acc_q <= s2_acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_grp_q <= s3_grp_d;
      s3_rem_q <= s3_rem_d;
    end
  end

  // Stage 4: century adjustment of the day count.
  logic [19:0] rem4;
  logic [1:0]  cent;
  logic [31:0] s4_acc_d, s4_acc_q;

  assign rem4 = {s3_rem_q, 2'b11};

  always_comb begin
    if (rem4 >= 20'(3 * dn2cd_pkg::DAYS_400Y)) begin
      cent = 2'd3;
    end else if (rem4 >= 20'(2 * dn2cd_pkg::DAYS_400Y)) begin
      cent = 2'd2;
    end else if (rem4 >= 20'(dn2cd_pkg::DAYS_400Y)) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
  end

  assign s4_acc_d = s3_acc_q + 32'd60 + 32'({s3_grp_q, 1'b0}) + 32'(s3_grp_q) + 32'(cent);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_acc_q <= s4_acc_d;
    end
  end

  // Stage 5: estimate of the 4-year group.
  logic [53:0] prod2;
  logic [31:0] s5_acc_q;
  logic [20:0] s5_qe_d, s5_qe_q;

  assign prod2   = 54'(s4_acc_q) * 54'(dn2cd_pkg::RECIP_4Y);
  assign s5_qe_d = prod2[52:32];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_acc_q <= s4_acc_q;
      s5_qe_q  <= s5_qe_d;
    end
  end

  // Stage 6: remainder of the estimate.
  logic [31:0] sub2;
  logic [20:0] s6_qe_q;
  logic [11:0] s6_rem_d, s6_rem_q;

  assign sub2     = s5_acc_q - 32'(s5_qe_q) * dn2cd_pkg::DAYS_4Y;
  assign s6_rem_d = sub2[11:0];

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_qe_q  <= s5_qe_q;
      s6_rem_q <= s6_rem_d;
    end
  end

  // Stage 7: correction of the 4-year quotient.
  logic        fix2;
  logic [11:0] rem2_adj;
  logic [20:0] s7_grp_d, s7_grp_q;
  logic [10:0] s7_rem_d, s7_rem_q;

  assign fix2     = s6_rem_q >= dn2cd_pkg::DAYS_4Y[11:0];
  assign rem2_adj = s6_rem_q - dn2cd_pkg::DAYS_4Y[11:0];
  assign s7_grp_d = fix2 ? s6_qe_q + 21'd1 : s6_qe_q;
  assign s7_rem_d = fix2 ? rem2_adj[10:0] : s6_rem_q[10:0];

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_grp_q <= s7_grp_d;
      s7_rem_q <= s7_rem_d;
    end
  end

  // Stage 8: year within the group and shifted day of year.
  logic [1:0]  yy;
  logic [10:0] vsum;
  logic [10:0] vmod;
  logic [8:0]  s8_doy_d, s8_doy_q;
  logic [23:0] s8_year_d, s8_year_q;

  always_comb begin
    if (s7_rem_q >= 11'd1096) begin
      yy = 2'd3;
    end else if (s7_rem_q >= 11'd731) begin
      yy = 2'd2;
    end else if (s7_rem_q >= 11'd366) begin
      yy = 2'd1;
    end else begin
      yy = 2'd0;
    end
    if (yy != 2'd0) begin
      vsum = s7_rem_q + 11'd305;
      if (vsum >= 11'd1460) begin
        vmod = vsum - 11'd1460;
      end else if (vsum >= 11'd1095) begin
        vmod = vsum - 11'd1095;
      end else if (vsum >= 11'd730) begin
        vmod = vsum - 11'd730;
      end else if (vsum >= 11'd365) begin
        vmod = vsum - 11'd365;
      end else begin
        vmod = vsum;
      end
    end else begin
      vsum = s7_rem_q + 11'd306;
      vmod = (vsum >= 11'd366) ? vsum - 11'd366 : vsum;
    end
  end

  assign s8_doy_d  = vmod[8:0] + 9'd123;
  assign s8_year_d = {1'b0, s7_grp_q, yy} - dn2cd_pkg::YEAR_BIAS;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_doy_q  <= s8_doy_d;
      s8_year_q <= s8_year_d;
    end
  end

  // Stage 9: month index.
  logic [20:0] prod3;
  logic [3:0]  s9_mq_d, s9_mq_q;
  logic [8:0]  s9_doy_q;
  logic [23:0] s9_year_q;

  assign prod3   = 21'(s8_doy_q) * 21'(dn2cd_pkg::MONTH_MUL);
  assign s9_mq_d = prod3[19:16];

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_mq_q   <= s9_mq_d;
      s9_doy_q  <= s8_doy_q;
      s9_year_q <= s8_year_q;
    end
  end

  // Stage 10: day, month and output word.
  logic [16:0] prod4;
  logic [8:0]  day_full;
  logic [4:0]  mq10;
  logic [4:0]  mon_full;
  logic        normal;
  logic [23:0] s10_year_d, s10_year_q;
  logic [3:0]  s10_month_d, s10_month_q;
  logic [4:0]  s10_day_d, s10_day_q;
  logic        s10_bc_d, s10_bc_q;

  assign prod4    = 17'(s9_mq_q) * 17'(dn2cd_pkg::DAY_MUL);
  assign day_full = s9_doy_q - prod4[16:8];
  assign mq10     = 5'(s9_mq_q) + 5'd10;

  always_comb begin
    if (mq10 >= 5'd24) begin
      mon_full = mq10 - 5'd23;
    end else if (mq10 >= 5'd12) begin
      mon_full = mq10 - 5'd11;
    end else begin
      mon_full = mq10 + 5'd1;
    end
  end

  assign normal      = stat_q[9] == dn2cd_pkg::ST_NORMAL;
  assign s10_year_d  = normal ? s9_year_q : '0;
  assign s10_month_d = normal ? mon_full[3:0] : '0;
  assign s10_day_d   = normal ? day_full[4:0] : '0;
  assign s10_bc_d    = normal && (s9_year_q[23] || s9_year_q == '0);

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_year_q  <= s10_year_d;
      s10_month_q <= s10_month_d;
      s10_day_q   <= s10_day_d;
      s10_bc_q    <= s10_bc_d;
    end
  end

  assign m_axis_tvalid = valid_q[NumStages-1];
  assign m_axis_tdata  = {6'd0, s10_bc_q, s10_day_q, s10_month_q, s10_year_q};
  assign m_axis_tuser  = stat_q[NumStages-1];

endmodule

// ===== hdl/dn2cd_checker.sv =====
module dn2cd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic [23:0] year;
  logic [3:0]  month;
  logic [4:0]  dom;
  logic        bc;
  logic        normal;

  assign year   = m_axis_tdata[23:0];
  assign month  = m_axis_tdata[27:24];
  assign dom    = m_axis_tdata[32:28];
  assign bc     = m_axis_tdata[33];
  assign normal = m_axis_tuser == dn2cd_pkg::ST_NORMAL;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage is empty");

  a_special_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !normal |-> m_axis_tdata == '0)
    else $error("special status with nonzero date fields");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && normal |->
      month >= 4'd1 && month <= 4'd12 && dom >= 5'd1 && dom <= 5'd31)
    else $error("month or day out of range");

  a_bc_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && normal |-> bc == (year[23] || year == '0))
    else $error("before_christ flag does not match year");

endmodule

bind day_number_to_calendar_date dn2cd_checker u_dn2cd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
